// ----- src/rgbyuv_pkg.sv -----
// Shared constants, register codes and pipeline control types for the RGB to YUV 4:2:0 block.
package rgbyuv_pkg;

	// Field widths
	localparam int unsigned PIX_W  = 8;
	localparam int unsigned CFG_W  = 13;
	localparam int unsigned ROW_W  = 12;
	localparam int unsigned CPOS_W = 11;

	// Frame geometry limits and reset values
	localparam int unsigned HEIGHT_LIMIT = 4096;
	localparam int unsigned WIDTH_RST    = 640;
	localparam int unsigned HEIGHT_RST   = 480;

	// BT.601 coefficients in thousandths
	localparam int unsigned K_YR    = 299;
	localparam int unsigned K_YG    = 587;
	localparam int unsigned K_YB    = 114;
	localparam int unsigned K_UR    = 169;
	localparam int unsigned K_UG    = 331;
	localparam int unsigned K_HALF  = 500;
	localparam int unsigned K_VG    = 419;
	localparam int unsigned K_VB    = 81;
	localparam int unsigned K_SCALE = 1000;

	// Chroma offset level
	localparam int unsigned OFFSET_LEVEL = 128;

	// Configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FRAME_WIDTH  = 1'b0;
	localparam cfg_idx_t CFG_FRAME_HEIGHT = 1'b1;

	// Per-pixel position flags carried down the pipeline
	typedef struct packed {
		logic              x_odd;
		logic              y_odd;
		logic              last_col;
		logic              last_row;
		logic              pad;
		logic              frame_end;
		logic [CPOS_W-1:0] col;
		logic [CPOS_W-1:0] row;
	} pix_ctrl_t;

endpackage

// ----- src/rgbyuv_csc.sv -----
// Two-stage fixed-point BT.601 color converter: per-pixel luma and unaveraged U and V.
module rgbyuv_csc #(
	parameter int unsigned COEF_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en_s2,
	input  logic                              en_s3,
	input  logic [rgbyuv_pkg::PIX_W-1:0]      red,
	input  logic [rgbyuv_pkg::PIX_W-1:0]      green,
	input  logic [rgbyuv_pkg::PIX_W-1:0]      blue,
	output logic [rgbyuv_pkg::PIX_W-1:0]      luma_s3,
	output logic [COEF_FRAC_BITS+7:0]         pix_u_s3,
	output logic [COEF_FRAC_BITS+7:0]         pix_v_s3
);
	import rgbyuv_pkg::*;

	localparam int unsigned F     = COEF_FRAC_BITS;
	localparam int unsigned PR_W  = F + 8;
	localparam int unsigned ACC_W = F + 10;
	localparam longint unsigned RND_K = K_SCALE / 2;

	// Coefficients rounded half up from thousandths
	localparam logic [F-1:0] C_YR = F'(((64'(K_YR) << F) + RND_K) / K_SCALE);
	localparam logic [F-1:0] C_YG = F'(((64'(K_YG) << F) + RND_K) / K_SCALE);
	localparam logic [F-1:0] C_YB = F'(((64'(K_YB) << F) + RND_K) / K_SCALE);
	localparam logic [F-1:0] C_UR = F'(((64'(K_UR) << F) + RND_K) / K_SCALE);
	localparam logic [F-1:0] C_UG = F'(((64'(K_UG) << F) + RND_K) / K_SCALE);
	localparam logic [F-1:0] C_HF = F'(((64'(K_HALF) << F) + RND_K) / K_SCALE);
	localparam logic [F-1:0] C_VG = F'(((64'(K_VG) << F) + RND_K) / K_SCALE);
	localparam logic [F-1:0] C_VB = F'(((64'(K_VB) << F) + RND_K) / K_SCALE);
	localparam logic [ACC_W-1:0] OFFSET = ACC_W'(OFFSET_LEVEL) << F;

	logic [PR_W-1:0] p_yr_s2, p_yg_s2, p_yb_s2;
	logic [PR_W-1:0] p_ub_s2, p_ur_s2, p_ug_s2;
	logic [PR_W-1:0] p_vr_s2, p_vg_s2, p_vb_s2;

	logic [ACC_W-1:0] luma_sum, luma_full;
	logic [ACC_W-1:0] base_u, neg_u, base_v, neg_v;
	logic [PR_W-1:0]  pu, pv;

	// Constant products
	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_yr_s2 <= PR_W'(C_YR) * PR_W'(red);
			p_yg_s2 <= PR_W'(C_YG) * PR_W'(green);
			p_yb_s2 <= PR_W'(C_YB) * PR_W'(blue);
			p_ub_s2 <= PR_W'(C_HF) * PR_W'(blue);
			p_ur_s2 <= PR_W'(C_UR) * PR_W'(red);
			p_ug_s2 <= PR_W'(C_UG) * PR_W'(green);
			p_vr_s2 <= PR_W'(C_HF) * PR_W'(red);
			p_vg_s2 <= PR_W'(C_VG) * PR_W'(green);
			p_vb_s2 <= PR_W'(C_VB) * PR_W'(blue);
		end
	end

	// Sums, truncation and clamping
	always_comb begin
		luma_sum  = ACC_W'(p_yr_s2) + ACC_W'(p_yg_s2) + ACC_W'(p_yb_s2);
		luma_full = luma_sum >> F;
		base_u    = OFFSET + ACC_W'(p_ub_s2);
		neg_u     = ACC_W'(p_ur_s2) + ACC_W'(p_ug_s2);
		base_v    = OFFSET + ACC_W'(p_vr_s2);
		neg_v     = ACC_W'(p_vg_s2) + ACC_W'(p_vb_s2);
		pu        = (base_u > neg_u) ? PR_W'(base_u - neg_u) : '0;
		pv        = (base_v > neg_v) ? PR_W'(base_v - neg_v) : '0;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			luma_s3  <= (luma_full > ACC_W'(255)) ? 8'hFF : luma_full[PIX_W-1:0];
			pix_u_s3 <= pu;
			pix_v_s3 <= pv;
		end
	end

endmodule

// ----- src/rgb_to_yuv420_subsampler_unit.sv -----
// Top level: raster RGB stream in, luma per pixel plus 2x2 averaged chroma out.
//
// One pixel per clock sustained while m_axis_tready does not stall the output.
// The pipeline is: input register, constant products, per-pixel Y/U/V, horizontal
// pair sum with a read of the chroma line store, block average into the output
// register. The line store (one entry of U and V pair sums per chroma column,
// MAX_WIDTH/2 deep) is read once per pixel and written at most once per pixel; a write and a read
// of the same column in the same cycle are forwarded. Every output field is
// valid on each beat; chroma fields are zero unless chroma_valid is set.
// A write to either configuration register restarts the frame at pixel zero;
// write only while no beat is in flight.
module rgb_to_yuv420_subsampler_unit #(
	parameter int unsigned MAX_WIDTH      = 4096,
	parameter int unsigned COEF_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input pixel stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [23:0]                     s_axis_tdata,  // red, green, blue
	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [47:0]                     m_axis_tdata,  // luma, chroma_u, chroma_v,
	                                                       // chroma_col, chroma_row
	output logic [1:0]                      m_axis_tuser,  // pad_after, chroma_valid
	output logic                            m_axis_tlast,  // frame_end
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  rgbyuv_pkg::cfg_idx_t            cfg_index,
	input  logic [rgbyuv_pkg::CFG_W-1:0]    cfg_data
);
	import rgbyuv_pkg::*;

	localparam int unsigned X_W         = $clog2(MAX_WIDTH);
	localparam int unsigned XW1         = X_W + 1;
	localparam int unsigned STORE_DEPTH = MAX_WIDTH / 2;
	localparam int unsigned A_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int unsigned F           = COEF_FRAC_BITS;
	localparam int unsigned PR_W        = F + 8;
	localparam int unsigned PS_W        = F + 9;
	localparam int unsigned BS_W        = F + 10;
	localparam int unsigned BW1         = BS_W + 1;
	localparam int unsigned W_RST_EFF   = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

	// Configuration, kept as last column / last row indexes
	logic [X_W-1:0]   wm1_q;
	logic             w_odd_q;
	logic [ROW_W-1:0] hm1_q;
	logic [XW1-1:0]   w_eff;
	logic [CFG_W-1:0] h_eff;
	logic             cfg_wr;

	// Raster position
	logic [X_W-1:0]   col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col_in, last_row_in;
	logic [X_W-1:0]   half_in;
	logic [A_W-1:0]   slot_in;

	// Pipeline valids and flow
	logic v1_q, v2_q, v3_q, v4_q, ov_q;
	logic free_out, free4, free3, free2, free1;
	logic leave1, leave2, leave3, leave4, take1;

	// Stage payloads
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;
	pix_ctrl_t        ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic [A_W-1:0]   slot_s1, slot_s2, slot_s3;
	logic [PIX_W-1:0] luma_s3, luma_s4;
	logic [PR_W-1:0]  pix_u_s3, pix_v_s3;
	logic             emit_s4;
	logic [BS_W-1:0]  su_s4, sv_s4;
	logic [1:0]       k_s4;

	// Line store and pair accumulator
	logic [2*PS_W-1:0] mem [STORE_DEPTH];
	logic [2*PS_W-1:0] rd_q, fwd_q, line_w, wdata;
	logic              fwd_hit_q;
	logic [PS_W-1:0]   pair_u_q, pair_v_q, pair_u_now, pair_v_now;
	logic              chroma_evt, store_evt, mem_we, emit3;
	logic [BS_W-1:0]   sum_u, sum_v;
	logic [1:0]        k3;

	// Output register
	logic [47:0] tdata_q;
	logic [1:0]  tuser_q;
	logic        tlast_q;
	logic [7:0]  avg_u, avg_v;

	// Rounded, saturated block average
	function automatic logic [7:0] block_avg(input logic [BS_W-1:0] sum, input logic [1:0] k);
		logic [BW1-1:0] rnd;
		logic [BW1-1:0] shf;
		rnd = BW1'(sum) + ((BW1'(1) << (F - 1)) << k);
		shf = (rnd >> F) >> k;
		return (shf > BW1'(255)) ? 8'hFF : shf[7:0];
	endfunction

	// Configuration port
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_comb begin
		if (cfg_data == '0) begin
			w_eff = XW1'(1);
			h_eff = CFG_W'(1);
		end else begin
			w_eff = (32'(cfg_data) > 32'(MAX_WIDTH)) ? XW1'(MAX_WIDTH) : XW1'(cfg_data);
			h_eff = (32'(cfg_data) > 32'(HEIGHT_LIMIT)) ? CFG_W'(HEIGHT_LIMIT) : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q   <= X_W'(W_RST_EFF - 1);
			w_odd_q <= 1'((W_RST_EFF % 2));
			hm1_q   <= ROW_W'(HEIGHT_RST - 1);
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					wm1_q   <= X_W'(w_eff - XW1'(1));
					w_odd_q <= w_eff[0];
				end
				CFG_FRAME_HEIGHT: begin
					hm1_q <= ROW_W'(h_eff - CFG_W'(1));
				end
				default: begin
				end
			endcase
		end
	end

	// Flow control: each stage moves when the next one has room
	always_comb begin
		free_out = !ov_q || m_axis_tready;
		leave4   = v4_q && free_out;
		free4    = !v4_q || free_out;
		leave3   = v3_q && free4;
		free3    = !v3_q || free4;
		leave2   = v2_q && free3;
		free2    = !v2_q || free3;
		leave1   = v1_q && free2;
		free1    = !v1_q || free2;
	end

	assign s_axis_tready = free1;
	assign take1         = s_axis_tvalid && free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (take1)       v1_q <= 1'b1;
			else if (leave1) v1_q <= 1'b0;
			if (leave1)      v2_q <= 1'b1;
			else if (leave2) v2_q <= 1'b0;
			if (leave2)      v3_q <= 1'b1;
			else if (leave3) v3_q <= 1'b0;
			if (leave3)      v4_q <= 1'b1;
			else if (leave4) v4_q <= 1'b0;
			if (leave4)      ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
		end
	end

	// Raster position and line store slot of the incoming pixel
	always_comb begin
		last_col_in = (col_q == wm1_q);
		last_row_in = (row_q == hm1_q);
		half_in     = col_q >> 1;
		slot_in     = ({1'b0, half_in} >= XW1'(STORE_DEPTH)) ? '0 : A_W'(half_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take1) begin
			if (last_col_in) begin
				col_q <= '0;
				row_q <= last_row_in ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + X_W'(1);
			end
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk) begin
		if (take1) begin
			red_s1             <= s_axis_tdata[7:0];
			green_s1           <= s_axis_tdata[15:8];
			blue_s1            <= s_axis_tdata[23:16];
			ctrl_s1.x_odd      <= col_q[0];
			ctrl_s1.y_odd      <= row_q[0];
			ctrl_s1.last_col   <= last_col_in;
			ctrl_s1.last_row   <= last_row_in;
			ctrl_s1.pad        <= last_col_in && w_odd_q;
			ctrl_s1.frame_end  <= last_col_in && last_row_in;
			ctrl_s1.col        <= CPOS_W'(half_in);
			ctrl_s1.row        <= CPOS_W'(row_q >> 1);
			slot_s1            <= slot_in;
		end
	end

	// Stages 2 and 3: color conversion
	rgbyuv_csc #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_csc (
		.clk      (clk),
		.en_s2    (leave1),
		.en_s3    (leave2),
		.red      (red_s1),
		.green    (green_s1),
		.blue     (blue_s1),
		.luma_s3  (luma_s3),
		.pix_u_s3 (pix_u_s3),
		.pix_v_s3 (pix_v_s3)
	);

	always_ff @(posedge clk) begin
		if (leave1) begin
			ctrl_s2 <= ctrl_s1;
			slot_s2 <= slot_s1;
		end
		if (leave2) begin
			ctrl_s3 <= ctrl_s2;
			slot_s3 <= slot_s2;
		end
	end

	// Stage 3: pair sum, line store write or block sum
	always_comb begin
		pair_u_now = ctrl_s3.x_odd ? pair_u_q + PS_W'(pix_u_s3) : PS_W'(pix_u_s3);
		pair_v_now = ctrl_s3.x_odd ? pair_v_q + PS_W'(pix_v_s3) : PS_W'(pix_v_s3);
		chroma_evt = ctrl_s3.x_odd || ctrl_s3.last_col;
		store_evt  = !ctrl_s3.y_odd && !ctrl_s3.last_row;
		mem_we     = leave3 && chroma_evt && store_evt;
		emit3      = chroma_evt && !store_evt;
		wdata      = {pair_v_now, pair_u_now};
		line_w     = fwd_hit_q ? fwd_q : rd_q;
		sum_u      = BS_W'(pair_u_now) + (ctrl_s3.y_odd ? BS_W'(line_w[PS_W-1:0]) : '0);
		sum_v      = BS_W'(pair_v_now) + (ctrl_s3.y_odd ? BS_W'(line_w[2*PS_W-1:PS_W]) : '0);
		k3         = {1'b0, ctrl_s3.x_odd} + {1'b0, ctrl_s3.y_odd};
	end

	// Line store: write on the pixel leaving stage 3, read for the one entering it
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_s3] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (leave2) begin
			rd_q      <= mem[slot_s2];
			fwd_hit_q <= mem_we && (slot_s3 == slot_s2);
			fwd_q     <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (leave3) begin
			pair_u_q <= pair_u_now;
			pair_v_q <= pair_v_now;
			luma_s4  <= luma_s3;
			ctrl_s4  <= ctrl_s3;
			emit_s4  <= emit3;
			su_s4    <= sum_u;
			sv_s4    <= sum_v;
			k_s4     <= k3;
		end
	end

	// Stage 4: block average into the output register
	always_comb begin
		avg_u = block_avg(su_s4, k_s4);
		avg_v = block_avg(sv_s4, k_s4);
	end

	always_ff @(posedge clk) begin
		if (leave4) begin
			tdata_q[7:0]   <= luma_s4;
			tdata_q[15:8]  <= emit_s4 ? avg_u : 8'h00;
			tdata_q[23:16] <= emit_s4 ? avg_v : 8'h00;
			tdata_q[34:24] <= emit_s4 ? ctrl_s4.col : '0;
			tdata_q[45:35] <= emit_s4 ? ctrl_s4.row : '0;
			tdata_q[47:46] <= 2'b00;
			tuser_q        <= {emit_s4, ctrl_s4.pad};
			tlast_q        <= ctrl_s4.frame_end;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
	assign m_axis_tlast  = tlast_q;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the RGB to YUV 4:2:0 converter: stream stimulus, predictor, scoreboard.
module tb_top;
	import rgbyuv_pkg::*;

	localparam int unsigned FRAC_BITS    = 16;
	localparam int unsigned LINE_W       = 4096;
	localparam int unsigned RAND_ITEMS   = 700;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	// Q16 coefficients, rounded half up from thousandths
	localparam longint unsigned C_YR   = ((64'(K_YR) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_YG   = ((64'(K_YG) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_YB   = ((64'(K_YB) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_UR   = ((64'(K_UR) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_UG   = ((64'(K_UG) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_HALF = ((64'(K_HALF) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_VG   = ((64'(K_VG) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_VB   = ((64'(K_VB) << FRAC_BITS) + K_SCALE / 2) / K_SCALE;
	localparam longint unsigned C_OFS  = 64'(OFFSET_LEVEL) << FRAC_BITS;

	typedef struct packed {
		logic [7:0]        luma;
		logic              pad_after;
		logic              chroma_valid;
		logic [7:0]        chroma_u;
		logic [7:0]        chroma_v;
		logic [CPOS_W-1:0] chroma_col;
		logic [CPOS_W-1:0] chroma_row;
		logic              frame_end;
	} yuv_res_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       typed;
		yuv_res_t   exp;
	} rgb_item_t;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		rgb_item_t        px;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;   // red, green, blue
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;   // luma, chroma_u, chroma_v, chroma_col, chroma_row
	logic [1:0] m_axis_tuser;    // pad_after, chroma_valid
	logic m_axis_tlast;          // frame_end
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// predictor state
	logic [CFG_W-1:0] frm_w = CFG_W'(WIDTH_RST);
	logic [CFG_W-1:0] frm_h = CFG_W'(HEIGHT_RST);
	int unsigned col_ct = 0;
	int unsigned row_ct = 0;
	longint unsigned acc_u = 0;
	longint unsigned acc_v = 0;
	longint unsigned line_u [LINE_W/2];
	longint unsigned line_v [LINE_W/2];

	// stimulus and scoreboard
	rgb_item_t rgb_pending_q[$];
	yuv_res_t yuv_due_q[$];
	stim_row_t dir_rows[$];
	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_fail = 0;
	int unsigned n_blocks = 0;
	int unsigned n_frames = 0;
	int unsigned n_pads = 0;
	int unsigned n_cfg = 0;
	int unsigned n_rand = 0;
	int unsigned cyc = 0;
	bit hold_req = 1'b0;

	rgb_to_yuv420_subsampler_unit #(
		.MAX_WIDTH(LINE_W),
		.COEF_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// U or V of one pixel, clamped at zero
	function automatic longint unsigned chroma_level(input longint unsigned pos,
			input longint unsigned neg);
		longint unsigned base;
		base = C_OFS + pos;
		return (base > neg) ? base - neg : 64'd0;
	endfunction

	// rounded block average over 2^k pixels, saturated
	function automatic logic [7:0] avg_sat(input longint unsigned sum, input int unsigned k);
		int unsigned sh;
		longint unsigned a;
		sh = FRAC_BITS + k;
		a = (sum + (64'd1 << (sh - 1))) >> sh;
		return (a > 255) ? 8'd255 : a[7:0];
	endfunction

	// one pixel through the converter; advances position and pair sums
	function automatic yuv_res_t convert_pixel(input logic [7:0] r, g, b);
		yuv_res_t res;
		int unsigned w, h, x, y, slot, k;
		bit last_c, last_r;
		longint unsigned ysum, pu, pv, su, sv;
		w = (frm_w == 0) ? 1 : ((frm_w > LINE_W) ? LINE_W : frm_w);
		h = (frm_h == 0) ? 1 : ((frm_h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : frm_h);
		x = col_ct;
		y = row_ct;
		last_c = (x + 1 >= w);
		last_r = (y + 1 >= h);
		slot = (x / 2) % (LINE_W / 2);
		res = '0;
		ysum = (C_YR * r + C_YG * g + C_YB * b) >> FRAC_BITS;
		res.luma = (ysum > 255) ? 8'd255 : ysum[7:0];
		pu = chroma_level(C_HALF * b, C_UR * r + C_UG * g);
		pv = chroma_level(C_HALF * r, C_VG * g + C_VB * b);
		if (x[0] == 1'b0) begin
			acc_u = pu;
			acc_v = pv;
		end else begin
			acc_u += pu;
			acc_v += pv;
		end
		res.pad_after = last_c && w[0];
		res.frame_end = last_c && last_r;
		if (x[0] || last_c) begin
			k = x[0];
			if (!y[0] && !last_r) begin
				// even row: park the pair sum for the row below
				line_u[slot] = acc_u;
				line_v[slot] = acc_v;
			end else begin
				su = acc_u;
				sv = acc_v;
				if (y[0]) begin
					su += line_u[slot];
					sv += line_v[slot];
					k++;
				end
				res.chroma_valid = 1'b1;
				res.chroma_u = avg_sat(su, k);
				res.chroma_v = avg_sat(sv, k);
				res.chroma_col = CPOS_W'(x / 2);
				res.chroma_row = CPOS_W'(y / 2);
			end
		end
		if (last_c) begin
			col_ct = 0;
			row_ct = last_r ? 0 : y + 1;
		end else begin
			col_ct = x + 1;
		end
		return res;
	endfunction

	function automatic logic [7:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic rgb_item_t rand_pixel();
		rgb_item_t it;
		it = '0;
		it.r = rand_comp();
		it.g = rand_comp();
		it.b = rand_comp();
		if ($urandom_range(0, 9) == 0) begin
			it.g = it.r;
			it.b = it.r;
		end
		return it;
	endfunction

	task automatic queue_pixel(input rgb_item_t it);
		n_queued++;
		rgb_pending_q.push_back(it);
	endtask

	task automatic add_cfg(input logic [CFG_W-1:0] w, h);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.w = w;
		row.h = h;
		row.px = '0;
		dir_rows.push_back(row);
	endtask

	task automatic add_pix(input logic [7:0] r, g, b);
		stim_row_t row;
		row.kind = ROW_PIX;
		row.w = '0;
		row.h = '0;
		row.px = '0;
		row.px.r = r;
		row.px.g = g;
		row.px.b = b;
		dir_rows.push_back(row);
	endtask

	// pixel with its result written out by hand
	task automatic add_typed(input logic [7:0] r, g, b, luma, input logic pad, cv,
			input logic [7:0] u, v, input int unsigned col, row_i, input logic fe);
		stim_row_t row;
		row.kind = ROW_PIX;
		row.w = '0;
		row.h = '0;
		row.px.r = r;
		row.px.g = g;
		row.px.b = b;
		row.px.typed = 1'b1;
		row.px.exp = '{luma, pad, cv, u, v, CPOS_W'(col), CPOS_W'(row_i), fe};
		dir_rows.push_back(row);
	endtask

	// wait until every queued pixel is in and every result is out
	task automatic settle();
		do @(posedge clk); while (n_accepted != n_queued || yuv_due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// width then height, back to back; each write restarts the frame
	task automatic write_frame_cfg(input logic [CFG_W-1:0] w, h);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= w;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		frm_w = w;
		col_ct = 0;
		row_ct = 0;
		acc_u = 0;
		acc_v = 0;
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data <= h;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		frm_h = h;
		col_ct = 0;
		row_ct = 0;
		acc_u = 0;
		acc_v = 0;
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	task automatic check_field(input string name, input int unsigned want, got);
		if (want != got) begin
			n_fail++;
			$display("%0t: %s mismatch on beat %0d, expected %0d, actual %0d",
				$time, name, n_checked, want, got);
		end
	endtask

	// pixel sender: bursts of random length with random gaps
	initial begin : tx_side
		rgb_item_t cur;
		yuv_res_t pred;
		int unsigned burst_left, gap_left;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cur = '0;
		burst_left = 0;
		gap_left = 0;
		foreach (line_u[i]) begin
			line_u[i] = 0;
			line_v[i] = 0;
		end
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready === 1'b1) begin
				pred = convert_pixel(cur.r, cur.g, cur.b);
				if (cur.typed)
					pred = cur.exp;
				yuv_due_q.push_back(pred);
				n_blocks += pred.chroma_valid;
				n_frames += pred.frame_end;
				n_pads += pred.pad_after;
				n_accepted++;
			end
			if (!(s_axis_tvalid && s_axis_tready !== 1'b1)) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (rgb_pending_q.size() != 0) begin
					cur = rgb_pending_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {cur.b, cur.g, cur.r};
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver: checks each beat, stalls on its own pattern
	initial begin : rx_side
		yuv_res_t act, want;
		int unsigned rx_mode, mode_left, hold_left, rx_cyc;
		logic rdy;
		m_axis_tready = 1'b0;
		rx_mode = 0;
		mode_left = 0;
		hold_left = 0;
		rx_cyc = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			rx_cyc++;
			if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
				act.luma = m_axis_tdata[7:0];
				act.chroma_u = m_axis_tdata[15:8];
				act.chroma_v = m_axis_tdata[23:16];
				act.chroma_col = m_axis_tdata[34:24];
				act.chroma_row = m_axis_tdata[45:35];
				act.pad_after = m_axis_tuser[0];
				act.chroma_valid = m_axis_tuser[1];
				act.frame_end = m_axis_tlast;
				if (yuv_due_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected beat, expected none, actual %h",
						$time, act);
				end else begin
					want = yuv_due_q.pop_front();
					check_field("luma", want.luma, act.luma);
					check_field("pad_after", want.pad_after, act.pad_after);
					check_field("chroma_valid", want.chroma_valid, act.chroma_valid);
					check_field("chroma_u", want.chroma_u, act.chroma_u);
					check_field("chroma_v", want.chroma_v, act.chroma_v);
					check_field("chroma_col", want.chroma_col, act.chroma_col);
					check_field("chroma_row", want.chroma_row, act.chroma_row);
					check_field("frame_end", want.frame_end, act.frame_end);
					n_checked++;
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 9) >= 3);
					2: rdy = ((rx_cyc % 7) >= 3);
					default: rdy = ($urandom_range(0, 9) < 3);
				endcase
			end
			m_axis_tready <= rdy;
		end
	end

	// watchdog
	initial begin : watchdog
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("%0t: timeout after %0d cycles, %0d results still due",
			$time, cyc, yuv_due_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	// main sequence
	initial begin : main_seq
		int unsigned w, h, cnt, frame_px;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset geometry, 3x3 with clipped blocks and pad, primaries,
		// out-of-range zero size, then a frame cut off by the next write
		add_typed(100, 100, 100, 100, 0, 0, 0, 0, 0, 0, 0);
		add_cfg(3, 3);
		add_typed(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_typed(255, 255, 255, 255, 0, 0, 0, 0, 0, 0, 0);
		add_typed(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
		add_typed(17, 17, 17, 17, 0, 0, 0, 0, 0, 0, 0);
		add_typed(200, 200, 200, 200, 0, 1, 128, 128, 0, 0, 0);
		add_typed(255, 255, 255, 255, 1, 1, 128, 128, 1, 0, 0);
		add_typed(128, 128, 128, 128, 0, 0, 0, 0, 0, 0, 0);
		add_typed(64, 64, 64, 64, 0, 1, 128, 128, 0, 1, 0);
		add_typed(1, 1, 1, 1, 1, 1, 128, 128, 1, 1, 1);
		add_cfg(2, 2);
		add_pix(255, 0, 0);
		add_pix(0, 255, 0);
		add_pix(0, 0, 255);
		add_pix(255, 0, 255);
		add_cfg(0, 0);
		add_typed(0, 0, 255, 29, 1, 1, 255, 107, 0, 0, 1);
		add_typed(255, 255, 255, 255, 1, 1, 128, 128, 0, 0, 1);
		add_cfg(4, 3);
		add_pix(37, 201, 90);
		add_pix(255, 255, 0);
		add_pix(0, 255, 255);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				write_frame_cfg(dir_rows[i].w, dir_rows[i].h);
			end else begin
				queue_pixel(dir_rows[i].px);
			end
		end

		// widest row on a one-row frame, cut short by the next write
		settle();
		write_frame_cfg(CFG_W'(LINE_W), 1);
		repeat (200) queue_pixel(rand_pixel());

		// one column, height written above the limit, cut short
		settle();
		write_frame_cfg(1, 13'h1FFF);
		repeat (200) queue_pixel(rand_pixel());

		// oversize width, cut short by the next write
		settle();
		write_frame_cfg(13'h1FFF, CFG_W'(HEIGHT_LIMIT));
		repeat (100) queue_pixel(rand_pixel());

		// output held off long enough that the input backs up
		settle();
		write_frame_cfg(16, 16);
		repeat (256) queue_pixel(rand_pixel());
		hold_req = 1'b1;

		// random geometries, mostly whole frames, some cut mid-frame
		while (n_rand < RAND_ITEMS) begin
			case ($urandom_range(0, 19))
				0: w = 0;
				1: w = $urandom_range(LINE_W + 1, 8191);
				2, 3, 4: w = $urandom_range(65, 200);
				5, 6, 7, 8, 9: w = $urandom_range(9, 64);
				default: w = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = $urandom_range(7, 20);
				default: h = $urandom_range(1, 6);
			endcase
			frame_px = ((w == 0) ? 1 : ((w > LINE_W) ? LINE_W : w)) * ((h == 0) ? 1 : h);
			if ($urandom_range(0, 9) < 7)
				cnt = frame_px * $urandom_range(1, 3);
			else
				cnt = $urandom_range(1, frame_px);
			if (cnt > 300)
				cnt = 300;
			settle();
			write_frame_cfg(CFG_W'(w), CFG_W'(h));
			repeat (cnt) begin
				queue_pixel(rand_pixel());
				n_rand++;
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (yuv_due_q.size() != 0) begin
			n_fail++;
			$display("%0t: %0d results never arrived", $time, yuv_due_q.size());
		end
		$display("Ran %0d pixels (%0d random) over %0d geometries in %0d cycles;",
			n_accepted, n_rand, n_cfg, cyc);
		$display("  %0d chroma blocks, %0d padded row ends, %0d frame ends checked, %0d errors",
			n_blocks, n_pads, n_frames, n_fail);
		if (n_fail == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
